>>> hw/rtl/fevag_pkg.sv
// Package for the frame energy voice activity gate.
// Holds register map, fixed-point constants and the back-end config bundle.
// No dependencies.
package fevag_pkg;

	localparam int unsigned REG_BYPASS   = 0;
	localparam int unsigned REG_FRAME    = 1;
	localparam int unsigned REG_MARGIN   = 2;
	localparam int unsigned REG_ALPHA    = 3;
	localparam int unsigned REG_MINSP    = 4;
	localparam int unsigned REG_MINSIL   = 5;
	localparam int unsigned REG_PREROLL  = 6;
	localparam int unsigned REG_POSTROLL = 7;

	localparam logic [2:0] ADDR_BYPASS   = 3'(REG_BYPASS);
	localparam logic [2:0] ADDR_FRAME    = 3'(REG_FRAME);
	localparam logic [2:0] ADDR_MARGIN   = 3'(REG_MARGIN);
	localparam logic [2:0] ADDR_ALPHA    = 3'(REG_ALPHA);
	localparam logic [2:0] ADDR_MINSP    = 3'(REG_MINSP);
	localparam logic [2:0] ADDR_MINSIL   = 3'(REG_MINSIL);
	localparam logic [2:0] ADDR_PREROLL  = 3'(REG_PREROLL);
	localparam logic [2:0] ADDR_POSTROLL = 3'(REG_POSTROLL);

	localparam logic signed [15:0] LEVEL_MIN   = -16'sd30720;
	localparam logic signed [15:0] FLOOR_RESET = -16'sd17920;
	localparam logic [9:0]  RUN_MAX   = 10'd1023;
	localparam logic [16:0] ALPHA_MIN = 17'd66;
	localparam logic [16:0] ALPHA_MAX = 17'd32768;
	localparam logic [17:0] DB_PER_LOG2 = 18'd197283;

	typedef struct packed {
		logic               bypass;
		logic signed [15:0] margin;
		logic [15:0]        alpha;
		logic [9:0]         min_speech;
		logic [9:0]         min_silence;
		logic [9:0]         preroll;
		logic [9:0]         postroll;
	} back_cfg_t;

endpackage

>>> hw/rtl/fevag_fifo.sv
// Two-entry queue between the sample accumulator and the level/decision engine.
// Plain registers; no package dependency.
module fevag_fifo #(
	parameter int unsigned W = 56
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> hw/rtl/fevag_front.sv
// Front end: takes samples, sums squares, cuts frames and queues frame totals.
// Uses fevag_fifo.
module fevag_front #(
	parameter int unsigned MAX_FRAME_SAMPLES = 4096,
	parameter int unsigned CNTW = 13,
	parameter int unsigned SUMW = 43
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [12:0]            frame_len,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [15:0]     in_sample,
	input  logic                   in_last,
	input  logic                   q_pop,
	output logic                   q_valid,
	output logic [SUMW+CNTW:0]     q_data
);

	localparam int unsigned FW = (CNTW > 13) ? CNTW : 13;
	localparam logic [FW-1:0] FMAX = FW'(MAX_FRAME_SAMPLES);

	logic [SUMW-1:0] sum_q, sum_nx;
	logic [CNTW-1:0] cnt_q, cnt_nx;
	logic [FW-1:0]   fs_raw, fs_eff;
	logic [31:0]     sq;
	logic            full, take, frame_end;

	assign fs_raw = FW'(frame_len);
	assign fs_eff = (fs_raw == '0) ? FW'(1) : ((fs_raw > FMAX) ? FMAX : fs_raw);

	assign sq        = 32'($signed(in_sample) * $signed(in_sample));
	assign sum_nx    = sum_q + SUMW'(sq);
	assign cnt_nx    = cnt_q + CNTW'(1);
	assign in_ready  = !full;
	assign take      = in_valid && in_ready;
	assign frame_end = (FW'(cnt_nx) >= fs_eff) || in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			sum_q <= frame_end ? '0 : sum_nx;
			cnt_q <= frame_end ? '0 : cnt_nx;
		end
	end

	fevag_fifo #(.W(SUMW + CNTW + 1)) u_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && frame_end),
		.push_data ({in_last, cnt_nx, sum_nx}),
		.full      (full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

endmodule

>>> hw/rtl/fevag_back.sv
// Back end: divide, log2, dB scaling, noise floor and speech state; drives results.
// Uses fevag_pkg.
module fevag_back #(
	parameter int unsigned FRAME_INDEX_BITS = 24,
	parameter int unsigned CNTW = 13,
	parameter int unsigned SUMW = 43,
	parameter int unsigned TDW = 96
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fevag_pkg::back_cfg_t  cfg,
	input  logic                  q_valid,
	input  logic [SUMW+CNTW:0]    q_data,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDW-1:0]        m_tdata,
	output logic                  m_tlast
);

	localparam int unsigned FIB = FRAME_INDEX_BITS;
	localparam int unsigned ITW = $clog2(SUMW);
	localparam logic [FIB-1:0] IDX_MAX = '1;
	localparam logic [38:0] DB_PER_LOG2_W = 39'(fevag_pkg::DB_PER_LOG2);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_NORM = 4'd3;
	localparam logic [3:0] ST_SQR  = 4'd4;
	localparam logic [3:0] ST_NEG  = 4'd5;
	localparam logic [3:0] ST_LVL  = 4'd6;
	localparam logic [3:0] ST_DEC  = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;
	localparam logic [3:0] ST_OUT1 = 4'd9;
	localparam logic [3:0] ST_OUT2 = 4'd10;

	logic [3:0]        st_q;
	logic [ITW-1:0]    it_q;
	logic [SUMW-1:0]   quo_q;
	logic [CNTW-1:0]   rem_q, div_q;
	logic              last_q;
	logic [30:0]       m_q;
	logic [4:0]        k_q;
	logic [15:0]       f_q;
	logic [38:0]       lprod_q;
	logic signed [15:0] db_q;
	logic signed [34:0] fprod_q;

	logic [FIB-1:0]    frame_q, cand_q;
	logic signed [15:0] floor_q;
	logic              active_q;
	logic [9:0]        srun_q, sil_q;

	logic              now_q, sp_q, kv_q, flush_q, upd_q;
	logic [FIB-1:0]    first_q, fin_q;

	logic              ov_q, olast_q;
	logic [TDW-1:0]    od_q;

	logic [CNTW:0]     remw;
	logic              qbit;
	logic [61:0]       sqp;
	logic [20:0]       neg;
	logic [39:0]       magr;
	logic [15:0]       mag;
	logic [16:0]       alpha_c;
	logic [9:0]        minsp, minsil;
	logic signed [17:0] thr;
	logic signed [16:0] diff;
	logic [FIB:0]      fsum;
	logic [FIB-1:0]    fsat, f0;
	logic              out_free, fin_item;

	logic              d_now, d_active, d_valid, d_upd;
	logic [9:0]        d_srun, d_sil;
	logic [FIB-1:0]    d_cand, d_first, d_fin;

	assign remw = {rem_q, quo_q[SUMW-1]};
	assign qbit = remw >= {1'b0, div_q};
	assign sqp  = 62'(m_q) * 62'(m_q);
	assign neg  = {k_q, 16'd0} - 21'(f_q);
	assign magr = 40'(lprod_q) + 40'(24'h800000);
	assign mag  = magr[39:24];

	assign alpha_c = (17'(cfg.alpha) < fevag_pkg::ALPHA_MIN) ? fevag_pkg::ALPHA_MIN :
		((17'(cfg.alpha) > fevag_pkg::ALPHA_MAX) ? fevag_pkg::ALPHA_MAX : 17'(cfg.alpha));
	assign minsp  = (cfg.min_speech == '0) ? 10'd1 : cfg.min_speech;
	assign minsil = (cfg.min_silence == '0) ? 10'd1 : cfg.min_silence;
	assign thr    = 18'(floor_q) + 18'(cfg.margin);
	assign diff   = 17'(db_q) - 17'(floor_q);
	assign fsum   = {1'b0, frame_q} + (FIB+1)'(cfg.postroll);
	assign fsat   = fsum[FIB] ? IDX_MAX : fsum[FIB-1:0];
	assign f0     = (frame_q >= FIB'(cfg.postroll)) ? frame_q - FIB'(cfg.postroll) : '0;

	always_comb begin
		d_now    = 18'(db_q) > thr;
		d_active = active_q;
		d_srun   = srun_q;
		d_sil    = sil_q;
		d_cand   = cand_q;
		d_valid  = 1'b0;
		d_first  = '0;
		d_fin    = '0;
		d_upd    = 1'b0;
		if (cfg.bypass) begin
			d_now   = 1'b0;
			d_valid = 1'b1;
			d_first = frame_q;
			d_fin   = frame_q;
		end else if (d_now) begin
			if (srun_q == '0) d_cand = frame_q;
			if (srun_q < fevag_pkg::RUN_MAX) d_srun = srun_q + 10'd1;
			d_sil = '0;
			d_upd = db_q < floor_q;
			if (!active_q && d_srun >= minsp) begin
				d_active = 1'b1;
				d_valid  = 1'b1;
				d_first  = (d_cand >= FIB'(cfg.preroll)) ? d_cand - FIB'(cfg.preroll) : '0;
				d_fin    = frame_q;
			end else if (active_q) begin
				d_valid = 1'b1;
				d_first = frame_q;
				d_fin   = frame_q;
			end
		end else begin
			if (sil_q < fevag_pkg::RUN_MAX) d_sil = sil_q + 10'd1;
			d_srun = '0;
			d_upd  = 1'b1;
			if (active_q) begin
				d_valid = 1'b1;
				d_first = frame_q;
				d_fin   = frame_q;
				if (d_sil >= minsil) begin
					d_fin    = fsat;
					d_active = 1'b0;
					d_sil    = '0;
				end
			end
		end
	end

	assign out_free = !ov_q || m_tready;
	assign fin_item = (st_q == ST_OUT1 && out_free && !flush_q) ||
		(st_q == ST_OUT2 && out_free);
	assign q_pop    = (st_q == ST_IDLE) && q_valid;
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tlast  = olast_q;

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				quo_q  <= q_data[SUMW-1:0];
				div_q  <= q_data[SUMW+CNTW-1:SUMW];
				last_q <= q_data[SUMW+CNTW];
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= qbit ? CNTW'(remw - {1'b0, div_q}) : remw[CNTW-1:0];
				quo_q <= {quo_q[SUMW-2:0], qbit};
			end
			ST_CHK: begin
				m_q <= {1'b0, quo_q[29:0]};
				k_q <= '0;
				f_q <= '0;
				if (quo_q == '0) db_q <= fevag_pkg::LEVEL_MIN;
				else db_q <= '0;
			end
			ST_NORM: begin
				if (!m_q[30]) begin
					m_q <= {m_q[29:0], 1'b0};
					k_q <= k_q + 5'd1;
				end
			end
			ST_SQR: begin
				m_q <= sqp[61] ? sqp[61:31] : sqp[60:30];
				f_q <= {f_q[14:0], sqp[61]};
			end
			ST_NEG: lprod_q <= 39'(neg) * DB_PER_LOG2_W;
			ST_LVL: db_q <= (mag > 16'd30720) ? fevag_pkg::LEVEL_MIN : -$signed(mag);
			ST_DEC: begin
				fprod_q <= 35'($signed({1'b0, alpha_c}) * diff);
				now_q   <= d_now;
				kv_q    <= d_valid;
				first_q <= d_first;
				fin_q   <= d_fin;
				upd_q   <= d_upd && !cfg.bypass;
				sp_q    <= cfg.bypass ? 1'b0 : d_active;
				flush_q <= last_q && !cfg.bypass && d_active;
			end
			default: ;
		endcase
		if (out_free && (st_q == ST_OUT1 || st_q == ST_OUT2)) begin
			if (st_q == ST_OUT1) begin
				od_q <= TDW'({fin_q, first_q, kv_q, sp_q, now_q, db_q, frame_q});
				olast_q <= last_q && !flush_q;
			end else begin
				od_q <= TDW'({frame_q, f0, 1'b1, sp_q, now_q, db_q, frame_q});
				olast_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			it_q     <= '0;
			ov_q     <= 1'b0;
			frame_q  <= '0;
			cand_q   <= '0;
			floor_q  <= fevag_pkg::FLOOR_RESET;
			active_q <= 1'b0;
			srun_q   <= '0;
			sil_q    <= '0;
		end else begin
			if (out_free && (st_q == ST_OUT1 || st_q == ST_OUT2)) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						st_q <= ST_DIV;
						it_q <= ITW'(SUMW - 1);
					end
				end
				ST_DIV: begin
					it_q <= it_q - ITW'(1);
					if (it_q == '0) st_q <= ST_CHK;
				end
				ST_CHK: begin
					if (quo_q == '0 || quo_q[SUMW-1:30] != '0) st_q <= ST_DEC;
					else st_q <= ST_NORM;
				end
				ST_NORM: begin
					if (m_q[30]) begin
						st_q <= ST_SQR;
						it_q <= ITW'(15);
					end
				end
				ST_SQR: begin
					it_q <= it_q - ITW'(1);
					if (it_q == '0) st_q <= ST_NEG;
				end
				ST_NEG: st_q <= ST_LVL;
				ST_LVL: st_q <= ST_DEC;
				ST_DEC: begin
					if (!cfg.bypass) begin
						active_q <= d_active;
						srun_q   <= d_srun;
						sil_q    <= d_sil;
						cand_q   <= d_cand;
					end
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_q) floor_q <= floor_q + 16'((fprod_q + 35'sd32768) >>> 16);
					st_q <= ST_OUT1;
				end
				ST_OUT1: begin
					if (out_free) st_q <= flush_q ? ST_OUT2 : ST_IDLE;
				end
				ST_OUT2: begin
					if (out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (fin_item) begin
				if (last_q) begin
					frame_q  <= '0;
					cand_q   <= '0;
					floor_q  <= fevag_pkg::FLOOR_RESET;
					active_q <= 1'b0;
					srun_q   <= '0;
					sil_q    <= '0;
				end else if (frame_q != IDX_MAX) begin
					frame_q <= frame_q + FIB'(1);
				end
			end
		end
	end

endmodule

>>> hw/rtl/frame_energy_voice_activity_gate.sv
// Top level of the frame energy voice activity gate: register file and the
// front/back split. Uses fevag_pkg, fevag_front, fevag_back.
//
// Samples are taken one per cycle while the two-entry frame queue has room.
// Each frame is then worked out by the back end in a single sequencer: it is
// taken from the queue and its SUMW-bit total divided by the sample count by
// restoring division (SUMW = 30 + clog2(MAX_FRAME_SAMPLES+1), 43 at the defaults);
// the mean is range checked, normalised and put through 16 squaring steps of the
// log unit, then scaled and rounded, the decision is made, the floor updated and
// the result beat loaded. A frame whose mean is zero or full scale skips the log
// unit. A flush beat, when one follows, adds a state; result beats wait on m_tready.
// A frame yields one result beat; the final sample of a recording may add a
// second that flushes the post-roll.
module frame_energy_voice_activity_gate #(
	parameter int unsigned MAX_FRAME_SAMPLES = 4096,
	parameter int unsigned FRAME_INDEX_BITS  = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_index, level_db, frame_voiced, seg_active, keep_valid, keep_first, keep_final
	output logic [((3*FRAME_INDEX_BITS+19+7)/8)*8-1:0] m_tdata,
	output logic        m_tlast
);

	localparam int unsigned CNTW = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int unsigned SUMW = 30 + CNTW;
	localparam int unsigned TDW  = ((3*FRAME_INDEX_BITS+19+7)/8)*8;

	logic        bypass_q;
	logic [12:0] frame_q;
	logic [15:0] margin_q, alpha_q;
	logic [9:0]  minsp_q, minsil_q, pre_q, post_q;
	logic        wr;
	logic        q_valid, q_pop;
	logic [SUMW+CNTW:0] q_data;
	fevag_pkg::back_cfg_t cfg;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			frame_q  <= 13'd320;
			margin_q <= 16'd2560;
			alpha_q  <= 16'd1311;
			minsp_q  <= 10'd6;
			minsil_q <= 10'd23;
			pre_q    <= 10'd6;
			post_q   <= 10'd9;
		end else if (wr) begin
			case (paddr[4:2])
				fevag_pkg::ADDR_BYPASS:   bypass_q <= pwdata[0];
				fevag_pkg::ADDR_FRAME:    frame_q  <= pwdata[12:0];
				fevag_pkg::ADDR_MARGIN:   margin_q <= pwdata[15:0];
				fevag_pkg::ADDR_ALPHA:    alpha_q  <= pwdata[15:0];
				fevag_pkg::ADDR_MINSP:    minsp_q  <= pwdata[9:0];
				fevag_pkg::ADDR_MINSIL:   minsil_q <= pwdata[9:0];
				fevag_pkg::ADDR_PREROLL:  pre_q    <= pwdata[9:0];
				fevag_pkg::ADDR_POSTROLL: post_q   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			fevag_pkg::ADDR_BYPASS:   prdata = 32'(bypass_q);
			fevag_pkg::ADDR_FRAME:    prdata = 32'(frame_q);
			fevag_pkg::ADDR_MARGIN:   prdata = 32'(margin_q);
			fevag_pkg::ADDR_ALPHA:    prdata = 32'(alpha_q);
			fevag_pkg::ADDR_MINSP:    prdata = 32'(minsp_q);
			fevag_pkg::ADDR_MINSIL:   prdata = 32'(minsil_q);
			fevag_pkg::ADDR_PREROLL:  prdata = 32'(pre_q);
			fevag_pkg::ADDR_POSTROLL: prdata = 32'(post_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.bypass      = bypass_q;
	assign cfg.margin      = $signed(margin_q);
	assign cfg.alpha       = alpha_q;
	assign cfg.min_speech  = minsp_q;
	assign cfg.min_silence = minsil_q;
	assign cfg.preroll     = pre_q;
	assign cfg.postroll    = post_q;

	fevag_front #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
		.CNTW              (CNTW),
		.SUMW              (SUMW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_len (frame_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample ($signed(s_tdata)),
		.in_last   (s_tlast),
		.q_pop     (q_pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	fevag_back #(
		.FRAME_INDEX_BITS (FRAME_INDEX_BITS),
		.CNTW             (CNTW),
		.SUMW             (SUMW),
		.TDW              (TDW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> hw/rtl/fevag_checker.sv
// Port-level checks for the voice activity gate, bound to the top level.
// No package dependency.
module fevag_checker #(
	parameter int unsigned FRAME_INDEX_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((3*FRAME_INDEX_BITS+19+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned FIB = FRAME_INDEX_BITS;

	logic signed [15:0] lvl;
	logic               kv;
	logic [FIB-1:0]     kf, kl;

	assign lvl = m_tdata[FIB+15:FIB];
	assign kv  = m_tdata[FIB+18];
	assign kf  = m_tdata[2*FIB+18:FIB+19];
	assign kl  = m_tdata[3*FIB+18:2*FIB+19];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kv |-> kf <= kl)
		else $error("keep range reversed");

	a_nokeep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !kv |-> kf == '0 && kl == '0)
		else $error("keep range set without keep_valid");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> lvl <= 16'sd0 && lvl >= -16'sd30720)
		else $error("level outside dBFS range");

endmodule

bind frame_energy_voice_activity_gate fevag_checker #(
	.FRAME_INDEX_BITS (FRAME_INDEX_BITS)
) u_fevag_checker (.*);

>>> tb/sv/frame_energy_voice_activity_gate_tb.sv
// Testbench for frame_energy_voice_activity_gate: drives samples and register writes,
// predicts every frame result and checks each output beat in order.
// Depends on fevag_pkg and the gate RTL.
module frame_energy_voice_activity_gate_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [23:0]        idx;
		logic signed [15:0] db;
		logic               now;
		logic               sp;
		logic               keep;
		logic [23:0]        first;
		logic [23:0]        fin;
		logic               eos;
	} frame_verdict_t;

	localparam longint unsigned IDX_MAX = 64'hFFFFFF;

	class vad_scoreboard;
		frame_verdict_t verdicts[$];
		int errors;
		// register copies
		bit r_bypass;
		bit [12:0] r_frame;
		bit [15:0] r_margin, r_alpha;
		bit [9:0] r_minsp, r_minsil, r_pre, r_post;
		// detector state
		longint unsigned energy;
		int unsigned count;
		longint unsigned frame_no;
		int floor_db;
		bit active;
		int unsigned sp_run, sil_run;
		longint unsigned candidate;

		function new();
			r_bypass = 0; r_frame = 320; r_margin = 2560; r_alpha = 1311;
			r_minsp = 6; r_minsil = 23; r_pre = 6; r_post = 9;
			errors = 0;
			clear();
		endfunction

		function void clear();
			energy = 0; count = 0; frame_no = 0; floor_db = fevag_pkg::FLOOR_RESET;
			active = 0; sp_run = 0; sil_run = 0; candidate = 0;
		endfunction

		function void set_reg(int unsigned r, bit [31:0] v);
			case (r)
				fevag_pkg::REG_BYPASS: r_bypass = v[0];
				fevag_pkg::REG_FRAME: r_frame = v[12:0];
				fevag_pkg::REG_MARGIN: r_margin = v[15:0];
				fevag_pkg::REG_ALPHA: r_alpha = v[15:0];
				fevag_pkg::REG_MINSP: r_minsp = v[9:0];
				fevag_pkg::REG_MINSIL: r_minsil = v[9:0];
				fevag_pkg::REG_PREROLL: r_pre = v[9:0];
				fevag_pkg::REG_POSTROLL: r_post = v[9:0];
				default: ;
			endcase
		endfunction

		function int frame_level(longint unsigned sum, int unsigned n);
			longint unsigned mean, m, neg, mag;
			int unsigned e, f;
			mean = sum / n;
			if (mean == 0) return fevag_pkg::LEVEL_MIN;
			if (mean >= (64'd1 << 30)) return 0;
			e = 0;
			while ((mean >> (e + 1)) != 0) e++;
			m = mean << (30 - e);
			f = 0;
			for (int i = 0; i < 16; i++) begin
				m = (m * m) >> 30;
				f = f << 1;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					f = f | 1;
				end
			end
			neg = longint'(30 - e) * 65536 - f;
			mag = (neg * fevag_pkg::DB_PER_LOG2 + (64'd1 << 23)) >> 24;
			if (mag > 30720) return fevag_pkg::LEVEL_MIN;
			return -int'(mag);
		endfunction

		function void track_floor(int db, int unsigned alpha);
			longint prod;
			prod = longint'(alpha) * longint'(db - floor_db) + 32768;
			floor_db += int'(prod >>> 16);
		endfunction

		function void note_sample(logic signed [15:0] s, bit last);
			int unsigned fs, alpha, minsp, minsil;
			int margin, db;
			longint unsigned idx, first, fin;
			bit now, keep, sp, flush;
			frame_verdict_t v;
			fs = r_frame == 0 ? 1 : (r_frame > 4096 ? 4096 : r_frame);
			alpha = r_alpha < fevag_pkg::ALPHA_MIN ? fevag_pkg::ALPHA_MIN :
				(r_alpha > fevag_pkg::ALPHA_MAX ? fevag_pkg::ALPHA_MAX : r_alpha);
			minsp = r_minsp == 0 ? 1 : r_minsp;
			minsil = r_minsil == 0 ? 1 : r_minsil;
			margin = $signed(r_margin);
			energy += longint'(s) * longint'(s);
			count++;
			if (count < fs && !last) return;
			idx = frame_no;
			db = frame_level(energy, count);
			now = 0; keep = 0; first = 0; fin = 0;
			if (r_bypass) begin
				keep = 1; first = idx; fin = idx;
			end else begin
				now = db > floor_db + margin;
				if (now) begin
					if (sp_run == 0) candidate = idx;
					if (sp_run < fevag_pkg::RUN_MAX) sp_run++;
					sil_run = 0;
					if (db < floor_db) track_floor(db, alpha);
					if (!active && sp_run >= minsp) begin
						active = 1; keep = 1; fin = idx;
						first = candidate >= r_pre ? candidate - r_pre : 0;
					end else if (active) begin
						keep = 1; first = idx; fin = idx;
					end
				end else begin
					if (sil_run < fevag_pkg::RUN_MAX) sil_run++;
					sp_run = 0;
					track_floor(db, alpha);
					if (active) begin
						keep = 1; first = idx; fin = idx;
						if (sil_run >= minsil) begin
							fin = idx + r_post;
							if (fin > IDX_MAX) fin = IDX_MAX;
							active = 0;
							sil_run = 0;
						end
					end
				end
			end
			if (frame_no < IDX_MAX) frame_no++;
			energy = 0;
			count = 0;
			sp = r_bypass ? 0 : active;
			flush = last && sp;
			v = '{idx[23:0], 16'(db), now, sp, keep, first[23:0], fin[23:0], last && !flush};
			verdicts.push_back(v);
			if (flush) begin
				first = idx >= r_post ? idx - r_post : 0;
				v = '{idx[23:0], 16'(db), now, sp, 1'b1, first[23:0], idx[23:0], 1'b1};
				verdicts.push_back(v);
			end
			if (last) clear();
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		task check_beat(logic [95:0] d, logic tl);
			frame_verdict_t w;
			if (verdicts.size() == 0) begin
				report("unexpected beat, frame", d[23:0], -1);
				return;
			end
			w = verdicts.pop_front();
			if (d[23:0] !== w.idx) report("frame_index", d[23:0], w.idx);
			if (d[39:24] !== w.db) report("level_db", $signed(d[39:24]), w.db);
			if (d[40] !== w.now) report("frame_voiced", d[40], w.now);
			if (d[41] !== w.sp) report("seg_active", d[41], w.sp);
			if (d[42] !== w.keep) report("keep_valid", d[42], w.keep);
			if (d[66:43] !== w.first) report("keep_first", d[66:43], w.first);
			if (d[90:67] !== w.fin) report("keep_final", d[90:67], w.fin);
			if (tl !== w.eos) report("end_of_stream", tl, w.eos);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic s_tvalid = 0, s_tready, s_tlast = 0;
	logic [15:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0, m_tlast;
	logic [95:0] m_tdata;

	vad_scoreboard sb = new();
	int src_idle = 0, snk_stall = 0;
	int sent = 0;

	frame_energy_voice_activity_gate uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	task apb_write(int unsigned r, bit [31:0] v);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(r * 4); pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(r, v);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task send_sample(logic signed [15:0] s, bit last);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1; s_tdata <= s; s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(s, last);
		sent++;
	endtask

	task drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task set_all(bit byp, int fr, int mg, int al, int msp, int msil, int pre, int post);
		apb_write(fevag_pkg::REG_BYPASS, 32'(byp));
		apb_write(fevag_pkg::REG_FRAME, 32'(fr));
		apb_write(fevag_pkg::REG_MARGIN, 32'(mg));
		apb_write(fevag_pkg::REG_ALPHA, 32'(al));
		apb_write(fevag_pkg::REG_MINSP, 32'(msp));
		apb_write(fevag_pkg::REG_MINSIL, 32'(msil));
		apb_write(fevag_pkg::REG_PREROLL, 32'(pre));
		apb_write(fevag_pkg::REG_POSTROLL, 32'(post));
	endtask

	task random_recording();
		int fs, frames, len, amp;
		bit loud;
		frames = $urandom_range(4, 30);
		fs = $urandom_range(0, 7) == 0 ? $urandom_range(9, 40) : $urandom_range(0, 8);
		if (fs == 0) fs = 1;
		set_all($urandom_range(7) == 0, $urandom_range(19) == 0 ? 0 : fs,
			$urandom_range(5) == 0 ? ($urandom_range(1) ? 24576 : -24576)
				: $urandom_range(0, 6000) - 1000,
			$urandom_range(3) == 0 ? $urandom_range(0, 65535) : $urandom_range(66, 32768),
			$urandom_range(0, 4), $urandom_range(0, 4),
			$urandom_range(3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 5),
			$urandom_range(3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 5));
		loud = $urandom_range(1);
		for (int f = 0; f < frames; f++) begin
			if ($urandom_range(3) == 0) loud = !loud;
			len = (f == frames - 1) ? $urandom_range(1, fs) : fs;
			for (int k = 0; k < len; k++) begin
				amp = loud ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 8) - 4;
				if (loud && $urandom_range(15) == 0) amp = $urandom_range(1) ? 32767 : -32768;
				send_sample(16'(amp), (f == frames - 1) && (k == len - 1));
			end
		end
		drain();
	endtask

	initial begin
		int rec;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// bypass, full-scale and silent frames
		set_all(1, 1, 2560, 1311, 6, 23, 6, 9);
		send_sample(0, 0);
		send_sample(16'sh7FFF, 0);
		send_sample(-16'sh8000, 1);
		drain();
		// onset with pre-roll, end with post-roll, then flush on the last sample
		set_all(0, 1, -24576, 32768, 2, 1, 3, 2);
		send_sample(-16'sh8000, 0);
		drain();
		apb_write(fevag_pkg::REG_MARGIN, 24576);
		send_sample(0, 0);
		drain();
		apb_write(fevag_pkg::REG_MARGIN, 0);
		send_sample(16'sh7FFF, 0);
		send_sample(-16'sh8000, 0);
		send_sample(16'sh7FFF, 0);
		send_sample(1, 0);
		send_sample(-1, 0);
		send_sample(16'sh7FFF, 0);
		send_sample(16'sh7FFF, 1);
		drain();
		// zero frame length, large post-roll and pre-roll
		set_all(0, 0, -24576, 0, 0, 0, 1023, 1023);
		send_sample(16'sh4000, 0);
		send_sample(-16'sh4000, 0);
		send_sample(3, 1);
		drain();
		// longest frame, cut short by the last sample
		set_all(0, 4096, 2560, 66, 1, 1, 0, 0);
		send_sample(16'sh1234, 0);
		send_sample(-16'sh5678, 0);
		send_sample(16'sh7FFF, 1);
		drain();

		rec = 0;
		while (sent < 1300) begin
			case (rec % 5)
				0: begin src_idle = 0; snk_stall = 0; end
				1: begin src_idle = 67; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 67; end
				3: begin src_idle = 26; snk_stall = 26; end
				default: begin src_idle = 0; snk_stall = 0; end
			endcase
			random_recording();
			rec++;
		end
		snk_stall = 0;
		drain();
		if (sb.errors == 0 && sb.verdicts.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
